// File: src/dark_pixel_centroid_marker_core_assert.svh
`ifndef DARK_PIXEL_CENTROID_MARKER_CORE_ASSERT_SVH
`define DARK_PIXEL_CENTROID_MARKER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define DPCM_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define DPCM_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/dpcm_pkg.sv
package dpcm_pkg;

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;
    localparam int COORD_W   = 11;
    localparam int SUM_W     = 33;
    localparam int CNT_W     = 23;
    localparam int DIV_CNT_W = $clog2(SUM_W);

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DARK_THRESHOLD = 2'd2;

    localparam logic [CFG_W-1:0]   WIDTH_RESET     = 12'd640;
    localparam logic [CFG_W-1:0]   HEIGHT_RESET    = 12'd480;
    localparam logic [PIX_W-1:0]   THRESHOLD_RESET = 8'd100;
    localparam logic [PIX_W-1:0]   PIX_WHITE       = 8'd255;
    localparam logic [COORD_W-1:0] MARKER_RESET    = 11'd95;

    typedef struct packed {
        logic accept;
        logic start_div;
        logic commit;
    } dpcm_cmd_t;

    typedef struct packed {
        logic last;
        logic dark_any;
        logic div_done;
    } dpcm_stat_t;

endpackage

// File: src/dpcm_div.sv
module dpcm_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [dpcm_pkg::SUM_W-1:0]   dividend,
    input  logic [dpcm_pkg::CNT_W-1:0]   divisor,
    output logic                         done,
    output logic [dpcm_pkg::SUM_W-1:0]   quotient
);
    import dpcm_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]     dvs_reg, dvs_next;
    logic [SUM_W-1:0]     quo_reg, quo_next;
    logic [CNT_W:0]       trial;
    logic                 fits;

    // restoring division, one quotient bit per cycle; dividend shifts out of quo_reg
    always_comb
    begin
        trial     = {rem_reg, quo_reg[SUM_W-1]};
        fits      = trial >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(SUM_W - 1);
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? CNT_W'(trial - {1'b0, dvs_reg}) : trial[CNT_W-1:0];
            quo_next = {quo_reg[SUM_W-2:0], fits};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: src/dpcm_ctrl.sv
module dpcm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  out_ready,
    input  dpcm_pkg::dpcm_stat_t  stat,
    output logic                  in_ready,
    output logic                  out_valid,
    output dpcm_pkg::dpcm_cmd_t   cmd
);
    import dpcm_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DIV  = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic slot_free;

    always_comb
    begin
        slot_free      = !out_valid_reg || out_ready;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = slot_free;
                cmd.accept = in_valid && slot_free;
                if (cmd.accept)
                begin
                    // frame end with dark pixels waits for the new centroid
                    if (stat.last && stat.dark_any)
                    begin
                        cmd.start_div  = 1'b1;
                        state_next     = ST_DIV;
                        out_valid_next = 1'b0;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                    end
                end
                else if (out_ready)
                begin
                    out_valid_next = 1'b0;
                end
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: src/dpcm_datapath.sv
module dpcm_datapath #(
    parameter int MAX_DIM = 2048
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [dpcm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dpcm_pkg::CFG_W-1:0]       cfg_data,
    input  logic [dpcm_pkg::PIX_W-1:0]       in_red,
    input  logic [dpcm_pkg::PIX_W-1:0]       in_green,
    input  logic [dpcm_pkg::PIX_W-1:0]       in_blue,
    input  dpcm_pkg::dpcm_cmd_t              cmd,
    output dpcm_pkg::dpcm_stat_t             stat,
    output logic [dpcm_pkg::PIX_W-1:0]       out_red,
    output logic [dpcm_pkg::PIX_W-1:0]       out_green,
    output logic [dpcm_pkg::PIX_W-1:0]       out_blue,
    output logic                             frame_end,
    output logic                             found,
    output logic [dpcm_pkg::COORD_W-1:0]     centroid_x,
    output logic [dpcm_pkg::COORD_W-1:0]     centroid_y
);
    import dpcm_pkg::*;

    localparam int CW = $clog2(MAX_DIM);
    localparam int DW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam int PW = ((CW > COORD_W) ? CW : COORD_W) + 1;

    logic [CFG_W-1:0]   width_reg, height_reg;
    logic [PIX_W-1:0]   thr_reg;

    logic [CW-1:0]      col_reg, col_next;
    logic [CW-1:0]      row_reg, row_next;
    logic [SUM_W-1:0]   sum_col_reg, sum_col_next;
    logic [SUM_W-1:0]   sum_row_reg, sum_row_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [COORD_W-1:0] marker_x_reg, marker_x_next;
    logic [COORD_W-1:0] marker_y_reg, marker_y_next;
    logic               found_reg, found_next;

    logic [PIX_W-1:0]   red_reg, green_reg, blue_reg;
    logic               frame_end_reg;

    logic [DW-1:0]      w_ext, h_ext, w_use, h_use;
    logic               row_end, last;
    logic               near_col, near_row, paint, dark;
    logic [PIX_W-1:0]   pix_r, pix_g, pix_b;
    logic [SUM_W-1:0]   sum_col_add, sum_row_add;
    logic [CNT_W-1:0]   cnt_add;
    logic               done_x, done_y;
    logic [SUM_W-1:0]   quo_x, quo_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            thr_reg    <= THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:    width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT:   height_reg <= cfg_data;
                CFG_DARK_THRESHOLD: thr_reg    <= cfg_data[PIX_W-1:0];
                default:            ;
            endcase
        end
    end

    // dimensions clamped to 1..MAX_DIM
    always_comb
    begin
        w_ext = DW'(width_reg);
        h_ext = DW'(height_reg);
        if (w_ext == '0)
            w_use = DW'(1);
        else if (w_ext > DW'(MAX_DIM))
            w_use = DW'(MAX_DIM);
        else
            w_use = w_ext;
        if (h_ext == '0)
            h_use = DW'(1);
        else if (h_ext > DW'(MAX_DIM))
            h_use = DW'(MAX_DIM);
        else
            h_use = h_ext;
    end

    assign row_end = (DW'(col_reg) + DW'(1)) >= w_use;
    assign last    = row_end && ((DW'(row_reg) + DW'(1)) >= h_use);

    // 2x2 square to the upper left of the marker, no wrap at zero
    assign near_col = (PW'(col_reg) == PW'(marker_x_reg))
                   || (PW'(col_reg) + PW'(1) == PW'(marker_x_reg));
    assign near_row = (PW'(row_reg) == PW'(marker_y_reg))
                   || (PW'(row_reg) + PW'(1) == PW'(marker_y_reg));
    assign paint    = near_col && near_row;

    assign pix_r = paint ? PIX_WHITE : in_red;
    assign pix_g = paint ? PIX_WHITE : in_green;
    assign pix_b = paint ? PIX_WHITE : in_blue;
    assign dark  = (pix_r < thr_reg) && (pix_g < thr_reg) && (pix_b < thr_reg);

    assign sum_col_add = dark ? sum_col_reg + SUM_W'(col_reg) : sum_col_reg;
    assign sum_row_add = dark ? sum_row_reg + SUM_W'(row_reg) : sum_row_reg;
    assign cnt_add     = dark ? cnt_reg + CNT_W'(1) : cnt_reg;

    assign stat.last     = last;
    assign stat.dark_any = cnt_add != '0;
    assign stat.div_done = done_x && done_y;

    dpcm_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start_div),
        .dividend (sum_col_add),
        .divisor  (cnt_add),
        .done     (done_x),
        .quotient (quo_x)
    );

    dpcm_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start_div),
        .dividend (sum_row_add),
        .divisor  (cnt_add),
        .done     (done_y),
        .quotient (quo_y)
    );

    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        sum_col_next  = sum_col_reg;
        sum_row_next  = sum_row_reg;
        cnt_next      = cnt_reg;
        marker_x_next = marker_x_reg;
        marker_y_next = marker_y_reg;
        found_next    = found_reg;
        if (cmd.accept)
        begin
            found_next = 1'b0;
            if (last)
            begin
                col_next     = '0;
                row_next     = '0;
                sum_col_next = '0;
                sum_row_next = '0;
                cnt_next     = '0;
            end
            else
            begin
                sum_col_next = sum_col_add;
                sum_row_next = sum_row_add;
                cnt_next     = cnt_add;
                if (row_end)
                begin
                    col_next = '0;
                    row_next = row_reg + CW'(1);
                end
                else
                begin
                    col_next = col_reg + CW'(1);
                end
            end
        end
        if (cmd.commit)
        begin
            found_next    = 1'b1;
            marker_x_next = quo_x[COORD_W-1:0];
            marker_y_next = quo_y[COORD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            sum_col_reg  <= '0;
            sum_row_reg  <= '0;
            cnt_reg      <= '0;
            marker_x_reg <= MARKER_RESET;
            marker_y_reg <= MARKER_RESET;
            found_reg    <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            sum_col_reg  <= sum_col_next;
            sum_row_reg  <= sum_row_next;
            cnt_reg      <= cnt_next;
            marker_x_reg <= marker_x_next;
            marker_y_reg <= marker_y_next;
            found_reg    <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            red_reg       <= pix_r;
            green_reg     <= pix_g;
            blue_reg      <= pix_b;
            frame_end_reg <= last;
        end
    end

    assign out_red    = red_reg;
    assign out_green  = green_reg;
    assign out_blue   = blue_reg;
    assign frame_end  = frame_end_reg;
    assign found      = found_reg;
    // marker only moves while no output is held, so it can drive the port directly
    assign centroid_x = marker_x_reg;
    assign centroid_y = marker_y_reg;

endmodule

// File: src/dark_pixel_centroid_marker_core.sv
// Dark pixel centroid marker: RGB pixels come in row order and go out one for one, with a
// white 2x2 square painted up and to the left of the current marker. Pixels with all three
// channels below dark_threshold are accumulated, and on the last pixel of a frame that holds
// dark pixels the marker moves to the mean column and row of those pixels. A new pixel is
// taken every cycle while out_ready keeps up; the last pixel of a frame that holds dark
// pixels waits for the two restoring dividers, which retire one quotient bit per cycle
// over the 33-bit coordinate sums. cfg_ready is always high; configuration must be written
// only between frames while the block is idle, which the block itself does not enforce.
module dark_pixel_centroid_marker_core #(
    parameter int MAX_DIM = 2048
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dpcm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dpcm_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [dpcm_pkg::PIX_W-1:0]       in_red,
    input  logic [dpcm_pkg::PIX_W-1:0]       in_green,
    input  logic [dpcm_pkg::PIX_W-1:0]       in_blue,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [dpcm_pkg::PIX_W-1:0]       out_red,
    output logic [dpcm_pkg::PIX_W-1:0]       out_green,
    output logic [dpcm_pkg::PIX_W-1:0]       out_blue,
    output logic                             frame_end,
    output logic                             found,
    output logic [dpcm_pkg::COORD_W-1:0]     centroid_x,
    output logic [dpcm_pkg::COORD_W-1:0]     centroid_y
);
    import dpcm_pkg::*;

    dpcm_cmd_t  cmd;
    dpcm_stat_t stat;

    assign cfg_ready = 1'b1;

    dpcm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    dpcm_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_red     (in_red),
        .in_green   (in_green),
        .in_blue    (in_blue),
        .cmd        (cmd),
        .stat       (stat),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .frame_end  (frame_end),
        .found      (found),
        .centroid_x (centroid_x),
        .centroid_y (centroid_y)
    );

endmodule

// File: src/dpcm_checker.sv
`include "dark_pixel_centroid_marker_core_assert.svh"

module dpcm_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [dpcm_pkg::PIX_W-1:0]       out_red,
    input logic [dpcm_pkg::PIX_W-1:0]       out_green,
    input logic [dpcm_pkg::PIX_W-1:0]       out_blue,
    input logic                             frame_end,
    input logic                             found,
    input logic [dpcm_pkg::COORD_W-1:0]     centroid_x,
    input logic [dpcm_pkg::COORD_W-1:0]     centroid_y
);

    // stalled result transaction holds its payload
    `DPCM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable({out_red, out_green, out_blue, frame_end, found}),
        "output payload changed while stalled")

    `DPCM_ASSERT_IMPL(a_found_at_end, out_valid && found, frame_end,
        "found raised away from frame end")

    // marker moves only together with a frame end that found dark pixels
    `DPCM_ASSERT_IMPL(a_marker_move, !$stable({centroid_x, centroid_y}),
        out_valid && found && frame_end,
        "centroid moved without a found frame end")

    `DPCM_ASSERT_IMPL(a_no_take_when_full, out_valid && !out_ready, !in_ready,
        "input taken while output slot is blocked")

endmodule

bind dark_pixel_centroid_marker_core dpcm_checker u_dpcm_checker (.*);

// File: tb/sv/tb_dark_pixel_centroid_marker_core.sv
`timescale 1ns / 1ps

module tb_dark_pixel_centroid_marker_core;
    import dpcm_pkg::*;

    localparam int DIM_LIMIT    = 2048;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 50;

    // index 3 maps to no register and must leave the block untouched
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        bit [PIX_W-1:0] red;
        bit [PIX_W-1:0] green;
        bit [PIX_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        bit [PIX_W-1:0]   red;
        bit [PIX_W-1:0]   green;
        bit [PIX_W-1:0]   blue;
        bit               frame_end;
        bit               found;
        bit [COORD_W-1:0] centroid_x;
        bit [COORD_W-1:0] centroid_y;
    } marked_pixel_t;

    localparam pixel_t BLACK_PIXEL = '0;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [PIX_W-1:0]     in_red;
    logic [PIX_W-1:0]     in_green;
    logic [PIX_W-1:0]     in_blue;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [PIX_W-1:0]     out_red;
    logic [PIX_W-1:0]     out_green;
    logic [PIX_W-1:0]     out_blue;
    logic                 frame_end;
    logic                 found;
    logic [COORD_W-1:0]   centroid_x;
    logic [COORD_W-1:0]   centroid_y;

    // predictor state
    bit [CFG_W-1:0]   cur_width     = WIDTH_RESET;
    bit [CFG_W-1:0]   cur_height    = HEIGHT_RESET;
    bit [PIX_W-1:0]   cur_threshold = THRESHOLD_RESET;
    bit [COORD_W-1:0] col_pos       = '0;
    bit [COORD_W-1:0] row_pos       = '0;
    bit [SUM_W-1:0]   col_sum       = '0;
    bit [SUM_W-1:0]   row_sum       = '0;
    bit [CNT_W-1:0]   dark_total    = '0;
    bit [COORD_W-1:0] mark_x        = MARKER_RESET;
    bit [COORD_W-1:0] mark_y        = MARKER_RESET;

    marked_pixel_t expected_pixels[$];
    int errors        = 0;
    int cycle_count   = 0;
    int pixels_sent   = 0;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    bit frame_closed  = 1'b0;

    dark_pixel_centroid_marker_core #(
        .MAX_DIM(DIM_LIMIT)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_red     (in_red),
        .in_green   (in_green),
        .in_blue    (in_blue),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .frame_end  (frame_end),
        .found      (found),
        .centroid_x (centroid_x),
        .centroid_y (centroid_y)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99, 0) >= sink_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // paint the marker square, accumulate dark pixels, move the marker at a frame end with dark pixels
    function automatic marked_pixel_t overlay_and_track(input pixel_t px);
        marked_pixel_t  res;
        int unsigned    w;
        int unsigned    h;
        bit             row_done;
        bit [SUM_W-1:0] quo;
        w = (cur_width == 0) ? 1 : ((cur_width > DIM_LIMIT) ? DIM_LIMIT : cur_width);
        h = (cur_height == 0) ? 1 : ((cur_height > DIM_LIMIT) ? DIM_LIMIT : cur_height);
        res = '0;
        res.red = px.red;
        res.green = px.green;
        res.blue = px.blue;
        if ((col_pos == mark_x || col_pos + 1 == mark_x)
            && (row_pos == mark_y || row_pos + 1 == mark_y))
        begin
            res.red = PIX_WHITE;
            res.green = PIX_WHITE;
            res.blue = PIX_WHITE;
        end
        if (res.red < cur_threshold && res.green < cur_threshold && res.blue < cur_threshold)
        begin
            col_sum = col_sum + col_pos;
            row_sum = row_sum + row_pos;
            dark_total = dark_total + 1'b1;
        end
        row_done = (col_pos + 1 >= w);
        res.frame_end = row_done && (row_pos + 1 >= h);
        if (res.frame_end)
        begin
            if (dark_total != 0)
            begin
                res.found = 1'b1;
                quo = col_sum / dark_total;
                mark_x = quo[COORD_W-1:0];
                quo = row_sum / dark_total;
                mark_y = quo[COORD_W-1:0];
            end
            col_pos = '0;
            row_pos = '0;
            col_sum = '0;
            row_sum = '0;
            dark_total = '0;
        end
        else if (row_done)
        begin
            col_pos = '0;
            row_pos = row_pos + 1'b1;
        end
        else
        begin
            col_pos = col_pos + 1'b1;
        end
        res.centroid_x = mark_x;
        res.centroid_y = mark_y;
        return res;
    endfunction

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            errors = errors + 1;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : check_output
        marked_pixel_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                errors = errors + 1;
                $display("%0t: output transaction with nothing expected, actual %0d/%0d/%0d",
                         $time, out_red, out_green, out_blue);
            end
            else
            begin
                want = expected_pixels.pop_front();
                check_field("out_red", want.red, out_red);
                check_field("out_green", want.green, out_green);
                check_field("out_blue", want.blue, out_blue);
                check_field("frame_end", want.frame_end, frame_end);
                check_field("found", want.found, found);
                check_field("centroid_x", want.centroid_x, centroid_x);
                check_field("centroid_y", want.centroid_y, centroid_y);
            end
        end
    end

    task automatic send_pixel(input pixel_t px);
        marked_pixel_t res;
        if ($urandom_range(99, 0) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99, 0) < src_idle_pct);
        end
        in_valid <= 1'b1;
        in_red <= px.red;
        in_green <= px.green;
        in_blue <= px.blue;
        do @(posedge clk); while (!in_ready);
        res = overlay_and_track(px);
        expected_pixels.push_back(res);
        frame_closed = res.frame_end;
        pixels_sent = pixels_sent + 1;
    endtask

    // stop sending and let every outstanding pixel come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_pixels.size() != 0);
    endtask

    // keep_valid holds cfg_valid high for a following write
    task automatic write_config(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data,
                                input bit keep_valid);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_FRAME_WIDTH:    cur_width = data;
            CFG_FRAME_HEIGHT:   cur_height = data;
            CFG_DARK_THRESHOLD: cur_threshold = data[PIX_W-1:0];
            default:            ;
        endcase
        if (!keep_valid)
            cfg_valid <= 1'b0;
    endtask

    task automatic set_frame_format(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                                    input logic [PIX_W-1:0] thr);
        bit poke_unused;
        poke_unused = ($urandom_range(3, 0) == 0);
        write_config(CFG_FRAME_WIDTH, w, 1'b1);
        write_config(CFG_FRAME_HEIGHT, h, 1'b1);
        write_config(CFG_DARK_THRESHOLD, {{(CFG_W-PIX_W){1'b0}}, thr}, poke_unused);
        if (poke_unused)
            write_config(CFG_UNUSED, CFG_W'($urandom), 1'b0);
    endtask

    function automatic pixel_t random_pixel(input int dark_pct);
        pixel_t px;
        px.red = PIX_W'($urandom);
        px.green = PIX_W'($urandom);
        px.blue = PIX_W'($urandom);
        if (cur_threshold != 0 && $urandom_range(99, 0) < dark_pct)
        begin
            px.red = PIX_W'($urandom_range(cur_threshold - 1, 0));
            px.green = PIX_W'($urandom_range(cur_threshold - 1, 0));
            px.blue = PIX_W'($urandom_range(cur_threshold - 1, 0));
            // one channel sitting right on the threshold spoils it
            if ($urandom_range(5, 0) == 0)
            begin
                case ($urandom_range(2, 0))
                    0:       px.red = cur_threshold;
                    1:       px.green = cur_threshold;
                    default: px.blue = cur_threshold;
                endcase
            end
        end
        return px;
    endfunction

    // reset format is 640x480, threshold 100, marker far away at 95,95
    task automatic test_channel_extremes();
        send_pixel(BLACK_PIXEL);
        send_pixel('{8'd255, 8'd255, 8'd255});
        send_pixel('{8'd99, 8'd99, 8'd99});
        send_pixel('{8'd100, 8'd0, 8'd0});
        send_pixel('{8'd0, 8'd100, 8'd0});
        send_pixel('{8'd0, 8'd0, 8'd100});
        send_pixel('{8'hAA, 8'h55, 8'h0F});
    endtask

    // shrink the frame while the column counter is already past the new width
    task automatic test_dimension_change_mid_frame();
        wait_drained();
        write_config(CFG_FRAME_WIDTH, 12'd2, 1'b1);
        write_config(CFG_FRAME_HEIGHT, 12'd2, 1'b0);
        repeat (3) send_pixel(BLACK_PIXEL);
    endtask

    // marker sits on row 0, so only one row of the square is painted
    task automatic test_marker_at_edge();
        repeat (4) send_pixel(BLACK_PIXEL);
        repeat (4) send_pixel(BLACK_PIXEL);
    endtask

    task automatic test_clamped_dimensions();
        wait_drained();
        write_config(CFG_FRAME_WIDTH, 12'd0, 1'b1);
        write_config(CFG_FRAME_HEIGHT, 12'd0, 1'b0);
        repeat (2) send_pixel(BLACK_PIXEL);
        wait_drained();
        write_config(CFG_FRAME_WIDTH, 12'hFFF, 1'b1);
        write_config(CFG_FRAME_HEIGHT, 12'hFFF, 1'b0);
        repeat (3) send_pixel(BLACK_PIXEL);
        wait_drained();
        write_config(CFG_FRAME_WIDTH, 12'd2, 1'b1);
        write_config(CFG_FRAME_HEIGHT, 12'd1, 1'b0);
        send_pixel(BLACK_PIXEL);
    endtask

    task automatic test_threshold_extremes();
        wait_drained();
        write_config(CFG_UNUSED, 12'hFFF, 1'b1);
        write_config(CFG_FRAME_WIDTH, 12'd2, 1'b1);
        write_config(CFG_FRAME_HEIGHT, 12'd2, 1'b1);
        write_config(CFG_DARK_THRESHOLD, 12'd0, 1'b0);
        repeat (4) send_pixel(BLACK_PIXEL);
        wait_drained();
        write_config(CFG_DARK_THRESHOLD, 12'd255, 1'b0);
        repeat (4) send_pixel('{8'd254, 8'd254, 8'd254});
    endtask

    task automatic test_random_frames(input int src_pct, input int sink_pct,
                                      input int item_target, input bit full_width_frame);
        int             start_count;
        int             frames;
        int             dark_pct;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        src_idle_pct = src_pct;
        sink_idle_pct = sink_pct;
        start_count = pixels_sent;
        if (full_width_frame)
        begin
            wait_drained();
            set_frame_format(12'hFFF, 12'd1, PIX_W'($urandom_range(255, 1)));
            do send_pixel(random_pixel(5)); while (!frame_closed);
        end
        while (pixels_sent - start_count < item_target)
        begin
            wait_drained();
            frames = $urandom_range(4, 1);
            if ($urandom_range(7, 0) == 0)
            begin
                w = CFG_W'($urandom_range(300, 13));
                h = CFG_W'($urandom_range(2, 1));
                frames = 1;
            end
            else
            begin
                w = CFG_W'($urandom_range(12, 0));
                h = CFG_W'($urandom_range(12, 0));
            end
            set_frame_format(w, h, PIX_W'($urandom_range(255, 0)));
            repeat (frames)
            begin
                case ($urandom_range(4, 0))
                    0:       dark_pct = 0;
                    1:       dark_pct = 10;
                    2:       dark_pct = 50;
                    3:       dark_pct = 90;
                    default: dark_pct = 100;
                endcase
                do
                begin
                    // now and then resize the row in the middle of a frame
                    if ($urandom_range(30, 0) == 0)
                    begin
                        wait_drained();
                        write_config(CFG_FRAME_WIDTH, CFG_W'($urandom_range(12, 0)), 1'b0);
                    end
                    send_pixel(random_pixel(dark_pct));
                end
                while (!frame_closed);
            end
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_FRAME_WIDTH;
        cfg_data <= '0;
        in_valid <= 1'b0;
        in_red <= '0;
        in_green <= '0;
        in_blue <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_channel_extremes();
        test_dimension_change_mid_frame();
        test_marker_at_edge();
        test_clamped_dimensions();
        test_threshold_extremes();
        test_random_frames(32, 57, 220, 1'b0);
        test_random_frames(57, 32, 220, 1'b0);
        test_random_frames(0, 0, 220, 1'b0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_pixels.size() != 0)
            errors = errors + 1;
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/dpcm_pkg.sv
src/dpcm_div.sv
src/dpcm_ctrl.sv
src/dpcm_datapath.sv
src/dark_pixel_centroid_marker_core.sv
src/dpcm_checker.sv
tb/sv/tb_dark_pixel_centroid_marker_core.sv
